### sv/rtd_pkg.sv
// ---------------------------------------------------------------------------
// rtd_pkg: shared types, constants and helpers
// Fixed-point helpers and the command/status bundles used between the
// controller and the datapath of the RTD resistance-to-temperature converter.
// ---------------------------------------------------------------------------
`default_nettype none
package rtd_pkg;

    localparam int MAX_ITERATIONS = 20;
    localparam int ITER_W = $clog2(MAX_ITERATIONS + 1);

    localparam logic signed [63:0] Q60_ONE   = 64'sh1000_0000_0000_0000;
    localparam logic signed [31:0] T_START   = 32'sd1638400;   // 25 C in Q.16
    localparam logic signed [63:0] T_HUNDRED = 64'sd6553600;   // 100 C in Q.16
    localparam logic signed [63:0] CONV_LSB  = 64'sd65;
    localparam logic signed [63:0] K_FOUR    = 64'sd4;
    localparam logic signed [63:0] K_THREE_HUNDRED = 64'sd300;

    localparam logic [5:0] SH_0  = 6'd0;
    localparam logic [5:0] SH_15 = 6'd15;
    localparam logic [5:0] SH_16 = 6'd16;
    localparam logic [5:0] SH_44 = 6'd44;
    localparam logic [5:0] SH_60 = 6'd60;

    // Configuration register indexes
    localparam logic [2:0] REG_NOMINAL = 3'd0;
    localparam logic [2:0] REG_COEF_A  = 3'd1;
    localparam logic [2:0] REG_COEF_B  = 3'd2;
    localparam logic [2:0] REG_COEF_C  = 3'd3;
    localparam logic [2:0] REG_WIRING  = 3'd4;

    // Wiring modes
    localparam logic [1:0] WIRE_TWO   = 2'd0;
    localparam logic [1:0] WIRE_THREE = 2'd1;

    // Result status codes
    localparam logic [1:0] ST_CONV    = 2'd0;
    localparam logic [1:0] ST_LIMIT   = 2'd1;
    localparam logic [1:0] ST_FLAT    = 2'd2;
    localparam logic [1:0] ST_R0_ZERO = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL_GO,
        S_MUL_WAIT,
        S_CHECK,
        S_DIV_GO,
        S_DIV_WAIT,
        S_DONE
    } t_state;

    // Multiply steps of one polynomial evaluation
    typedef enum logic [3:0] {
        M_T2,
        M_AT,
        M_BT,
        M_BT2,
        M_T3,
        M_Q,
        M_S1,
        M_S2,
        M_CQ,
        M_CI,
        M_RC,
        M_SL
    } t_mstep;

    typedef struct packed {
        logic   load;
        logic   zero_t;
        logic   mul_go;
        logic   div_go;
        logic   update;
        logic   emit;
        t_mstep step;
    } t_cmd;

    typedef struct packed {
        logic r0_zero;
        logic mul_done;
        logic div_done;
        logic t_neg;
        logic slope_zero;
        logic conv;
    } t_stat;

    // Give a magnitude a sign, saturating to the signed 64-bit range
    function automatic logic signed [63:0] apply_sign(input logic [63:0] mag,
                                                      input logic neg);
        logic signed [63:0] res;
        if (neg) begin
            if (mag[63]) begin
                res = 64'sh8000_0000_0000_0000;
            end else begin
                res = -$signed(mag);
            end
        end else begin
            if (mag[63]) begin
                res = 64'sh7FFF_FFFF_FFFF_FFFF;
            end else begin
                res = $signed(mag);
            end
        end
        return res;
    endfunction

    // Saturating signed 64-bit add
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        logic signed [63:0] res;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            res = s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end else begin
            res = s[63:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### sv/rtd_mul.sv
// ---------------------------------------------------------------------------
// rtd_mul: sequential signed 64x64 multiply with shift and saturation
// Four 32x32 partial products, one per cycle, then a truncating right shift
// of the 128-bit magnitude and saturation to 64 bits.
// ---------------------------------------------------------------------------
`default_nettype none
module rtd_mul
    import rtd_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  wire signed [63:0]  i_a,
    input  wire signed [63:0]  i_b,
    input  wire        [5:0]   i_sh,
    output logic               o_done,
    output logic signed [63:0] o_res
);

    logic         r_busy;
    logic [2:0]   r_cnt;
    logic         r_neg;
    logic [63:0]  r_ua;
    logic [63:0]  r_ub;
    logic [5:0]   r_sh;
    logic [127:0] r_acc;
    logic         r_done;
    logic signed [63:0] r_res;

    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [63:0]  prod;
    logic [127:0] part;
    logic [127:0] shifted;
    logic [63:0]  mag;

    // Select the partial product for this cycle
    always_comb begin
        a_half = r_cnt[0] ? r_ua[63:32] : r_ua[31:0];
        b_half = r_cnt[1] ? r_ub[63:32] : r_ub[31:0];
        prod   = a_half * b_half;
        unique case (r_cnt[1:0])
            2'd0:    part = {64'd0, prod};
            2'd3:    part = {prod, 64'd0};
            default: part = {32'd0, prod, 32'd0};
        endcase
        shifted = r_acc >> r_sh;
        mag     = (shifted[127:64] != 64'd0) ? '1 : shifted[63:0];
    end

    // Control of the multiply sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 3'd1;
                end
            end
        end
    end

    // Operand capture, accumulation and result
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_a[63] ^ i_b[63];
            r_ua  <= i_a[63] ? 64'(-i_a) : i_a;
            r_ub  <= i_b[63] ? 64'(-i_b) : i_b;
            r_sh  <= i_sh;
            r_acc <= 128'd0;
        end else if (r_busy) begin
            if (r_cnt == 3'd4) begin
                r_res <= apply_sign(mag, r_neg);
            end else begin
                r_acc <= r_acc + part;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule
`default_nettype wire

### sv/rtd_div.sv
// ---------------------------------------------------------------------------
// rtd_div: sequential signed Q.32 divide
// Computes (num * 2^32) / den truncated toward zero, saturated, one
// quotient bit per cycle after a single overflow check.
// ---------------------------------------------------------------------------
`default_nettype none
module rtd_div
    import rtd_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  wire signed [63:0]  i_num,
    input  wire signed [63:0]  i_den,
    output logic               o_done,
    output logic signed [63:0] o_res
);

    logic        r_busy;
    logic        r_chk;
    logic [5:0]  r_cnt;
    logic        r_neg;
    logic [63:0] r_n;
    logic [63:0] r_d;
    logic [63:0] r_rem;
    logic [62:0] r_lo;
    logic [62:0] r_q;
    logic        r_done;
    logic signed [63:0] r_res;

    logic        ovf;
    logic [64:0] rem2;
    logic        qbit;
    logic [64:0] rem_sub;
    logic [62:0] q_next;

    // Overflow check and one restoring step
    always_comb begin
        ovf     = {31'd0, r_n} >= {r_d, 31'd0};
        rem2    = {r_rem, r_lo[62]};
        qbit    = rem2 >= {1'b0, r_d};
        rem_sub = rem2 - {1'b0, r_d};
        q_next  = {r_q[61:0], qbit};
    end

    // Control of the divide sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_chk  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_chk  <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                if (r_chk) begin
                    r_chk <= 1'b0;
                    if (ovf) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end else if (r_cnt == 6'd62) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 6'd1;
                end
            end
        end
    end

    // Operand capture, remainder update and result
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[63] ^ i_den[63];
            r_n   <= i_num[63] ? 64'(-i_num) : i_num;
            r_d   <= i_den[63] ? 64'(-i_den) : i_den;
        end else if (r_busy) begin
            if (r_chk) begin
                r_rem <= {31'd0, r_n[63:31]};
                r_lo  <= {r_n[30:0], 32'd0};
                r_q   <= 63'd0;
                if (ovf) begin
                    r_res <= apply_sign('1, r_neg);
                end
            end else begin
                r_rem <= qbit ? rem_sub[63:0] : rem2[63:0];
                r_lo  <= {r_lo[61:0], 1'b0};
                r_q   <= q_next;
                if (r_cnt == 6'd62) begin
                    r_res <= apply_sign({1'b0, q_next}, r_neg);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule
`default_nettype wire

### sv/rtd_dp.sv
// ---------------------------------------------------------------------------
// rtd_dp: datapath of the RTD converter
// Holds the corrected resistance, the temperature estimate and the
// polynomial terms; runs the shared multiplier and the divider.
// ---------------------------------------------------------------------------
`default_nettype none
module rtd_dp
    import rtd_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  t_cmd               i_cmd,
    input  wire        [31:0]  i_measured_resistance,
    input  wire        [23:0]  i_lead_resistance,
    input  wire        [31:0]  i_nominal,
    input  wire signed [63:0]  i_coef_a,
    input  wire signed [63:0]  i_coef_b,
    input  wire signed [63:0]  i_coef_c,
    input  wire        [1:0]   i_wiring,
    output t_stat              o_stat,
    output logic signed [19:0] o_temperature
);

    logic signed [63:0] r_r;
    logic signed [31:0] r_t;
    logic signed [63:0] r_t2;
    logic signed [63:0] r_t3;
    logic signed [63:0] r_q;
    logic signed [63:0] r_s1;
    logic signed [63:0] r_inner;
    logic signed [63:0] r_poly;
    logic signed [63:0] r_dpoly;
    logic signed [63:0] r_rc;
    logic signed [63:0] r_slope;
    logic signed [63:0] r_dt;
    logic signed [19:0] r_temp;

    logic signed [63:0] t64;
    logic signed [63:0] tm;
    logic signed [63:0] meas;
    logic signed [63:0] lead;
    logic signed [63:0] corr;
    logic signed [63:0] mul_a;
    logic signed [63:0] mul_b;
    logic        [5:0]  mul_sh;
    logic               mul_done;
    logic signed [63:0] mul_res;
    logic               div_done;
    logic signed [63:0] div_res;
    logic signed [63:0] t_sum;
    logic signed [31:0] t_new;
    logic signed [23:0] t_div;
    logic signed [19:0] t_sat;

    // Lead compensation and operand selection
    always_comb begin
        t64  = {{32{r_t[31]}}, r_t};
        tm   = t64 - T_HUNDRED;
        meas = {32'd0, i_measured_resistance};
        lead = {40'd0, i_lead_resistance};
        if (i_wiring == WIRE_TWO) begin
            corr = meas - (lead <<< 1);
        end else if (i_wiring == WIRE_THREE) begin
            corr = meas - lead;
        end else begin
            corr = meas;
        end
        unique case (i_cmd.step)
            M_T2:    begin mul_a = t64;      mul_b = t64;     mul_sh = SH_16; end
            M_AT:    begin mul_a = i_coef_a; mul_b = t64;     mul_sh = SH_16; end
            M_BT:    begin mul_a = i_coef_b; mul_b = t64;     mul_sh = SH_15; end
            M_BT2:   begin mul_a = i_coef_b; mul_b = r_t2;    mul_sh = SH_16; end
            M_T3:    begin mul_a = r_t2;     mul_b = t64;     mul_sh = SH_16; end
            M_Q:     begin mul_a = r_t3;     mul_b = tm;      mul_sh = SH_16; end
            M_S1:    begin mul_a = r_t3;     mul_b = K_FOUR;  mul_sh = SH_0;  end
            M_S2:    begin mul_a = r_t2;     mul_b = K_THREE_HUNDRED; mul_sh = SH_0; end
            M_CQ:    begin mul_a = i_coef_c; mul_b = r_q;     mul_sh = SH_16; end
            M_CI:    begin mul_a = i_coef_c; mul_b = r_inner; mul_sh = SH_16; end
            M_RC:    begin mul_a = {32'd0, i_nominal}; mul_b = r_poly;  mul_sh = SH_60; end
            M_SL:    begin mul_a = {32'd0, i_nominal}; mul_b = r_dpoly; mul_sh = SH_44; end
            default: begin mul_a = t64;      mul_b = t64;     mul_sh = SH_16; end
        endcase
    end

    // Temperature update with clamp to 32 bits, and output scaling
    always_comb begin
        t_sum = sat_add(t64, r_dt);
        if (t_sum > 64'sd2147483647) begin
            t_new = 32'sh7FFF_FFFF;
        end else if (t_sum < -64'sd2147483648) begin
            t_new = 32'sh8000_0000;
        end else begin
            t_new = t_sum[31:0];
        end
        t_div = r_t[31:8];
        if (t_div > 24'sd524287) begin
            t_sat = 20'sd524287;
        end else if (t_div < -24'sd524288) begin
            t_sat = -20'sd524288;
        end else begin
            t_sat = t_div[19:0];
        end
    end

    rtd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_go),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_sh    (mul_sh),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    rtd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_go),
        .i_num   (r_r - r_rc),
        .i_den   (r_slope),
        .o_done  (div_done),
        .o_res   (div_res)
    );

    // Load, write back products and apply Newton steps
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_r <= corr;
            r_t <= T_START;
        end
        if (i_cmd.zero_t) begin
            r_t <= 32'sd0;
        end
        if (i_cmd.update) begin
            r_t <= t_new;
        end
        if (div_done) begin
            r_dt <= div_res;
        end
        if (i_cmd.emit) begin
            r_temp <= t_sat;
        end
        if (mul_done) begin
            unique case (i_cmd.step)
                M_T2:    r_t2    <= mul_res;
                M_AT:    r_poly  <= sat_add(Q60_ONE, mul_res);
                M_BT:    r_dpoly <= sat_add(i_coef_a, mul_res);
                M_BT2:   r_poly  <= sat_add(r_poly, mul_res);
                M_T3:    r_t3    <= mul_res;
                M_Q:     r_q     <= mul_res;
                M_S1:    r_s1    <= mul_res;
                M_S2:    r_inner <= sat_add(r_s1, 64'(-mul_res));
                M_CQ:    r_poly  <= sat_add(r_poly, mul_res);
                M_CI:    r_dpoly <= sat_add(r_dpoly, mul_res);
                M_RC:    r_rc    <= mul_res;
                M_SL:    r_slope <= mul_res;
                default: r_t2    <= mul_res;
            endcase
        end
    end

    always_comb begin
        o_stat.r0_zero    = (i_nominal == 32'd0);
        o_stat.mul_done   = mul_done;
        o_stat.div_done   = div_done;
        o_stat.t_neg      = r_t[31];
        o_stat.slope_zero = (r_slope == 64'sd0);
        o_stat.conv       = (r_dt >= -CONV_LSB) && (r_dt <= CONV_LSB);
    end

    assign o_temperature = r_temp;

endmodule
`default_nettype wire

### sv/rtd_ctrl.sv
// ---------------------------------------------------------------------------
// rtd_ctrl: controller of the RTD converter
// Sequences the multiply steps of each evaluation, the divide and the
// Newton update; owns the handshakes, status and step count.
// ---------------------------------------------------------------------------
`default_nettype none
module rtd_ctrl
    import rtd_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    input  t_stat       i_stat,
    output t_cmd        o_cmd,
    output logic [1:0]  o_status,
    output logic [4:0]  o_iterations_used
);

    t_state              r_state, n_state;
    t_mstep              r_step, n_step;
    logic [ITER_W-1:0]   r_steps, n_steps;
    logic [1:0]          r_status, n_status;
    logic                r_out_valid, n_out_valid;
    logic [1:0]          r_out_status, n_out_status;
    logic [4:0]          r_out_iter, n_out_iter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= M_T2;
            r_steps     <= '0;
            r_status    <= ST_CONV;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_steps     <= n_steps;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_iter   <= n_out_iter;
    end

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_steps      = r_steps;
        n_status     = r_status;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_iter   = r_out_iter;
        o_cmd        = '0;
        o_cmd.step   = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_steps    = '0;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                if (i_stat.r0_zero) begin
                    o_cmd.zero_t = 1'b1;
                    n_status     = ST_R0_ZERO;
                    n_state      = S_DONE;
                end else begin
                    n_step  = M_T2;
                    n_state = S_MUL_GO;
                end
            end
            S_MUL_GO: begin
                o_cmd.mul_go = 1'b1;
                n_state      = S_MUL_WAIT;
            end
            S_MUL_WAIT: begin
                if (i_stat.mul_done) begin
                    n_state = S_MUL_GO;
                    unique case (r_step)
                        M_T2:    n_step = M_AT;
                        M_AT:    n_step = M_BT;
                        M_BT:    n_step = M_BT2;
                        M_BT2:   n_step = i_stat.t_neg ? M_T3 : M_RC;
                        M_T3:    n_step = M_Q;
                        M_Q:     n_step = M_S1;
                        M_S1:    n_step = M_S2;
                        M_S2:    n_step = M_CQ;
                        M_CQ:    n_step = M_CI;
                        M_CI:    n_step = M_RC;
                        M_RC:    n_step = M_SL;
                        M_SL:    n_state = S_CHECK;
                        default: n_step = M_T2;
                    endcase
                end
            end
            S_CHECK: begin
                if (i_stat.slope_zero) begin
                    n_status = ST_FLAT;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_DIV_GO;
                end
            end
            S_DIV_GO: begin
                o_cmd.div_go = 1'b1;
                n_state      = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                // Apply the step in the cycle after the quotient lands
                if (i_stat.div_done) begin
                    n_state = S_DIV_WAIT;
                end
                if (!i_stat.div_done && !o_cmd.div_go && r_step == M_SL
                        && r_status == ST_LIMIT) begin
                    o_cmd.update = 1'b1;
                    n_steps      = r_steps + 1'b1;
                    n_status     = ST_CONV;
                    if (i_stat.conv) begin
                        n_status = ST_CONV;
                        n_state  = S_DONE;
                    end else if (r_steps + 1'b1 == ITER_W'(MAX_ITERATIONS)) begin
                        n_status = ST_LIMIT;
                        n_state  = S_DONE;
                    end else begin
                        n_step  = M_T2;
                        n_state = S_MUL_GO;
                    end
                end else if (i_stat.div_done) begin
                    n_status = ST_LIMIT;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.emit   = 1'b1;
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_iter   = 5'(r_steps);
                    n_status     = ST_CONV;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_iterations_used = r_out_iter;

endmodule
`default_nettype wire

### sv/rtd_resistance_to_temperature_top.sv
// Schedule: setup, then per Newton step 6 multiplies at or above 0 C or 12 below 0 C
// on the shared 32x32 multiplier, a slope check, and the start, run and application
// of the bit-serial divide, up to 20 steps.
// Throughput: one transaction at a time; a new one is taken once the result
// is registered, while that result may still wait at the output.
// Reset: synchronous, active low; control clears, config registers reload.
// ---------------------------------------------------------------------------
// rtd_resistance_to_temperature_top: RTD resistance to temperature converter
// Lead compensation, then Newton inversion of the Callendar-Van Dusen curve,
// with an APB-style configuration port.
// ---------------------------------------------------------------------------
`default_nettype none
module rtd_resistance_to_temperature_top
    import rtd_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire        [31:0]  i_measured_resistance,
    input  wire        [23:0]  i_lead_resistance,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic signed [19:0] o_temperature,
    output logic       [1:0]   o_status,
    output logic       [4:0]   o_iterations_used,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire        [5:0]   paddr,
    input  wire        [63:0]  pwdata,
    output logic       [63:0]  prdata,
    output logic               pready
);

    logic [31:0]        r_nominal;
    logic signed [63:0] r_coef_a;
    logic signed [63:0] r_coef_b;
    logic signed [63:0] r_coef_c;
    logic [1:0]         r_wiring;
    logic               cfg_wr;
    t_cmd               cmd;
    t_stat              stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nominal <= 32'd6553600;
            r_coef_a  <= 64'sd4505963116454940;
            r_coef_b  <= -64'sd665812168910;
            r_coef_c  <= -64'sd4822671;
            r_wiring  <= 2'd2;
        end else if (cfg_wr) begin
            unique case (paddr[5:3])
                REG_NOMINAL: r_nominal <= pwdata[31:0];
                REG_COEF_A:  r_coef_a  <= pwdata;
                REG_COEF_B:  r_coef_b  <= pwdata;
                REG_COEF_C:  r_coef_c  <= pwdata;
                REG_WIRING:  r_wiring  <= pwdata[1:0];
                default:     ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (paddr[5:3])
            REG_NOMINAL: prdata = {32'd0, r_nominal};
            REG_COEF_A:  prdata = r_coef_a;
            REG_COEF_B:  prdata = r_coef_b;
            REG_COEF_C:  prdata = r_coef_c;
            REG_WIRING:  prdata = {62'd0, r_wiring};
            default:     prdata = 64'd0;
        endcase
    end

    rtd_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_stat            (stat),
        .o_cmd             (cmd),
        .o_status          (o_status),
        .o_iterations_used (o_iterations_used)
    );

    rtd_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .i_measured_resistance (i_measured_resistance),
        .i_lead_resistance     (i_lead_resistance),
        .i_nominal             (r_nominal),
        .i_coef_a              (r_coef_a),
        .i_coef_b              (r_coef_b),
        .i_coef_c              (r_coef_c),
        .i_wiring              (r_wiring),
        .o_stat                (stat),
        .o_temperature         (o_temperature)
    );

`ifndef SYNTH
    a_r0_zero_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_R0_ZERO) |-> (o_temperature == 20'sd0))
        else $error("zero nominal resistance must give zero temperature");

    a_conv_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_CONV) |-> (o_iterations_used != 5'd0))
        else $error("converged result must report at least one step");

    a_limit_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_LIMIT)
            |-> (o_iterations_used == 5'(MAX_ITERATIONS)))
        else $error("iteration limit must report the full step count");
`endif

endmodule
`default_nettype wire

### tb/tb.sv
// ---------------------------------------------------------------------------
// tb: self-checking testbench for rtd_resistance_to_temperature_top
// Drives resistance samples through the valid/stall input channel, predicts
// each temperature reading with a bit-exact fixed-point Newton solver, and
// checks every reading in order. Covers lead compensation modes, zero R0,
// flat slope, iteration limit, coefficient extremes and output back-pressure.
// ---------------------------------------------------------------------------
`default_nettype none

class rtd_scoreboard;
    typedef struct {
        logic signed [19:0] temperature;
        logic [1:0]         status;
        logic [4:0]         iterations;
    } reading_t;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic [1:0] WIRE_FOUR = 2'd2;

    reading_t expected_readings[$];
    int errors;

    logic [31:0]        r0;
    logic signed [63:0] ca, cb, cc;
    logic [1:0]         wiring;

    function new();
        errors = 0;
        r0 = 32'd6553600;
        ca = 64'sd4505963116454940;
        cb = -64'sd665812168910;
        cc = -64'sd4822671;
        wiring = WIRE_FOUR;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] value);
        case (idx)
            rtd_pkg::REG_NOMINAL: r0 = value[31:0];
            rtd_pkg::REG_COEF_A:  ca = value;
            rtd_pkg::REG_COEF_B:  cb = value;
            rtd_pkg::REG_COEF_C:  cc = value;
            rtd_pkg::REG_WIRING:  wiring = value[1:0];
            default: ;
        endcase
    endfunction

    // Attach a sign to a magnitude, saturating to 64 bits
    function logic signed [63:0] signed_sat(logic [63:0] mag, logic neg);
        if (neg)
            return mag[63] ? S64_MIN : -$signed(mag);
        return mag[63] ? S64_MAX : $signed(mag);
    endfunction

    function logic signed [63:0] add_sat(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    // Exact product, shift toward zero, saturate
    function logic signed [63:0] prod_shift(logic signed [63:0] a, logic signed [63:0] b,
                                           int sh);
        logic [63:0]  ua, ub, lo;
        logic [127:0] p;
        ua = a[63] ? 64'd0 - a : a;
        ub = b[63] ? 64'd0 - b : b;
        p = {64'd0, ua} * {64'd0, ub};
        p = p >> sh;
        lo = (p[127:64] != 0) ? '1 : p[63:0];
        return signed_sat(lo, a[63] ^ b[63]);
    endfunction

    // (num << 32) / den toward zero, saturated
    function logic signed [63:0] quot_q32(logic signed [63:0] num, logic signed [63:0] den);
        logic [63:0] n, d;
        logic [95:0] q;
        logic        neg;
        neg = num[63] ^ den[63];
        n = num[63] ? 64'd0 - num : num;
        d = den[63] ? 64'd0 - den : den;
        if (n / d >= 64'h8000_0000)
            return signed_sat('1, neg);
        q = {n, 32'd0} / {32'd0, d};
        return signed_sat(q[63:0], neg);
    endfunction

    // Note an accepted sample and queue its predicted reading
    function void note_sample(logic [31:0] meas, logic [23:0] lead);
        logic signed [63:0] r, t, t2, t3, tm, qq, inner, poly, dpoly, rc, slope, dt, r0s;
        logic signed [63:0] tout;
        reading_t exp_r;
        r = {32'd0, meas};
        if (wiring == rtd_pkg::WIRE_TWO)
            r = r - 2 * $signed({40'd0, lead});
        else if (wiring == rtd_pkg::WIRE_THREE)
            r = r - $signed({40'd0, lead});
        r0s = {32'd0, r0};
        t = 64'sd1638400;
        exp_r.status = rtd_pkg::ST_LIMIT;
        exp_r.iterations = 0;
        if (r0 == 0) begin
            t = 0;
            exp_r.status = rtd_pkg::ST_R0_ZERO;
        end else begin
            for (int k = 0; k < 20; k++) begin
                t2 = prod_shift(t, t, 16);
                poly = add_sat(64'sh1000_0000_0000_0000, prod_shift(ca, t, 16));
                dpoly = add_sat(ca, prod_shift(cb, t, 15));
                poly = add_sat(poly, prod_shift(cb, t2, 16));
                if (t < 0) begin
                    t3 = prod_shift(t2, t, 16);
                    tm = t - 64'sd6553600;
                    qq = prod_shift(t3, tm, 16);
                    inner = add_sat(prod_shift(t3, 64'sd4, 0), -prod_shift(t2, 64'sd300, 0));
                    poly = add_sat(poly, prod_shift(cc, qq, 16));
                    dpoly = add_sat(dpoly, prod_shift(cc, inner, 16));
                end
                rc = prod_shift(r0s, poly, 60);
                slope = prod_shift(r0s, dpoly, 44);
                if (slope == 0) begin
                    exp_r.status = rtd_pkg::ST_FLAT;
                    break;
                end
                dt = quot_q32(r - rc, slope);
                t = add_sat(t, dt);
                if (t > 64'sh7FFF_FFFF) t = 64'sh7FFF_FFFF;
                if (t < -64'sh8000_0000) t = -64'sh8000_0000;
                exp_r.iterations++;
                if (dt >= -64'sd65 && dt <= 64'sd65) begin
                    exp_r.status = rtd_pkg::ST_CONV;
                    break;
                end
            end
        end
        tout = t >>> 8;
        if (tout > 64'sd524287) tout = 64'sd524287;
        if (tout < -64'sd524288) tout = -64'sd524288;
        exp_r.temperature = tout[19:0];
        expected_readings.push_back(exp_r);
    endfunction

    // Compare one reading against the oldest prediction
    function void check_reading(logic signed [19:0] temp, logic [1:0] st, logic [4:0] it);
        reading_t e;
        if (expected_readings.size() == 0) begin
            $display("%0t: unexpected reading temp=%0d status=%0d iter=%0d",
                     $time, temp, st, it);
            errors++;
            return;
        end
        e = expected_readings.pop_front();
        if (temp !== e.temperature) begin
            $display("%0t: temperature expected %0d actual %0d", $time, e.temperature, temp);
            errors++;
        end
        if (st !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, st);
            errors++;
        end
        if (it !== e.iterations) begin
            $display("%0t: iterations expected %0d actual %0d", $time, e.iterations, it);
            errors++;
        end
    endfunction
endclass

module tb;
    import rtd_pkg::*;

    localparam logic [1:0] WIRE_FOUR   = 2'd2;
    localparam logic [1:0] WIRE_SPARE  = 2'd3;
    localparam int         IDLE_LIMIT  = 30000;
    localparam int         HOLD_CYCLES = 6000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic        [31:0] i_measured_resistance = '0;
    logic        [23:0] i_lead_resistance = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [19:0] o_temperature;
    logic        [1:0]  o_status;
    logic        [4:0]  o_iterations_used;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic        [5:0]  paddr = '0;
    logic        [63:0] pwdata = '0;
    logic        [63:0] prdata;
    logic               pready;

    rtd_scoreboard sb = new();
    bit  quiet = 0;
    bit  pressure_req = 0;
    int  idle_cycles = 0;

    rtd_resistance_to_temperature_top uut (.*);

    always #5 i_clk = ~i_clk;

    // Check every reading taken at the output
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_reading(o_temperature, o_status, o_iterations_used);
    end

    // Stop the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stall the output in random bursts, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (pressure_req) begin
                pressure_req = 0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Write one register through the configuration port while idle
    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    // Offer one sample and hold it until accepted
    task automatic send_sample(logic [31:0] meas, logic [23:0] lead);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid            <= 1'b1;
        i_measured_resistance <= meas;
        i_lead_resistance     <= lead;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_sample(meas, lead);
    endtask

    // Wait until every reading is back, then let the block settle
    task automatic drain();
        @(posedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.expected_readings.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // Random samples: mostly plausible sensor values, some raw noise
    task automatic random_samples(int count);
        logic [31:0] meas;
        logic [23:0] lead;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 6) == 0) begin
                meas = $urandom;
                lead = 24'($urandom);
            end else begin
                meas = 32'((64'(sb.r0) * $urandom_range(180, 3950)) / 1000);
                lead = 24'($urandom_range(0, 3 << 16));
            end
            send_sample(meas, lead);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed extremes with reset coefficients (four-wire)
        send_sample(32'd0, 24'd0);
        send_sample(32'hFFFF_FFFF, 24'hFF_FFFF);
        send_sample(32'd6553600, 24'd0);
        send_sample(32'd9076909, 24'd1234);
        send_sample(32'd1213727, 24'd0);
        send_sample(32'd25590048, 24'd0);
        drain();

        // Lead compensation in every wiring mode
        write_reg(REG_WIRING, {62'd0, WIRE_TWO});
        send_sample(32'd6553600, 24'hFF_FFFF);
        send_sample(32'hFFFF_FFFF, 24'hFF_FFFF);
        send_sample(32'd6684672, 24'd65536);
        random_samples(12);
        drain();
        write_reg(REG_WIRING, {62'd0, WIRE_THREE});
        send_sample(32'd6619136, 24'd65536);
        send_sample(32'd0, 24'hFF_FFFF);
        random_samples(12);
        drain();
        write_reg(REG_WIRING, {62'd0, WIRE_SPARE});
        send_sample(32'd7000000, 24'hFF_FFFF);
        random_samples(8);
        drain();

        // Zero nominal resistance
        write_reg(REG_NOMINAL, 64'd0);
        send_sample(32'd6553600, 24'd0);
        random_samples(6);
        drain();

        // Flat slope: no linear, quadratic or cubic term
        write_reg(REG_NOMINAL, 64'd6553600);
        write_reg(REG_COEF_A, 64'd0);
        write_reg(REG_COEF_B, 64'd0);
        write_reg(REG_COEF_C, 64'd0);
        send_sample(32'd6553600, 24'd0);
        random_samples(6);
        drain();

        // Coefficient and nominal extremes
        write_reg(REG_NOMINAL, 64'hFFFF_FFFF);
        write_reg(REG_COEF_A, 64'h7FFF_FFFF_FFFF_FFFF);
        write_reg(REG_COEF_B, 64'h8000_0000_0000_0000);
        write_reg(REG_COEF_C, 64'h7FFF_FFFF_FFFF_FFFF);
        random_samples(10);
        drain();
        write_reg(REG_NOMINAL, 64'd1);
        write_reg(REG_COEF_A, 64'h8000_0000_0000_0000);
        write_reg(REG_COEF_B, 64'h7FFF_FFFF_FFFF_FFFF);
        write_reg(REG_COEF_C, 64'h8000_0000_0000_0000);
        random_samples(10);
        drain();

        // Pt100 coefficients, mixed wiring and nominal values
        write_reg(REG_COEF_A, 64'd4505963116454940);
        write_reg(REG_COEF_B, -64'sd665812168910);
        write_reg(REG_COEF_C, -64'sd4822671);
        write_reg(REG_WIRING, {62'd0, WIRE_TWO});
        random_samples(40);
        pressure_req = 1;
        random_samples(30);
        drain();
        write_reg(REG_NOMINAL, 64'd65536000);
        write_reg(REG_WIRING, {62'd0, WIRE_FOUR});
        random_samples(60);
        drain();
        write_reg(REG_NOMINAL, {32'd0, 32'($urandom)});
        write_reg(REG_WIRING, {62'd0, WIRE_THREE});
        random_samples(30);
        quiet = 1;
        random_samples(40);
        drain();

        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

`default_nettype wire

### rtd_resistance_to_temperature_top.f
sv/rtd_pkg.sv
sv/rtd_mul.sv
sv/rtd_div.sv
sv/rtd_dp.sv
sv/rtd_ctrl.sv
sv/rtd_resistance_to_temperature_top.sv
tb/tb.sv
